@@ rtl/ranked_score_table_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the ranked score table
// Concurrent assertion wrappers; they compile to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef RANKED_SCORE_TABLE_MACROS_SVH
`define RANKED_SCORE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define RST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define RST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RST_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define RST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ rtl/rst_pkg.sv @@
// ---------------------------------------------------------------------------
// Ranked score table package
// Shared widths, codes and control types of the table and its cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rst_pkg;

	localparam int RST_DEPTH      = 64;
	localparam int RST_NAME_BYTES = 8;
	localparam int MAX_RESULTS    = 64;
	localparam int SCORE_W        = 32;
	localparam int NAME_KEY_W     = 64;
	localparam int COUNT_W        = 7;
	localparam int RANK_W         = 6;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_TOP    = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_EVAL,
		ST_INS_APPLY,
		ST_DEL_SCAN,
		ST_TOP_EMIT,
		ST_RESTORE,
		ST_STATUS
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_EVAL,
		CELL_INSERT,
		CELL_ROTATE,
		CELL_SHIFT_LEFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     occ;
		logic     wrap;
	} cell_ctl_t;

endpackage

@@ rtl/rst_if.sv @@
// ---------------------------------------------------------------------------
// Ranked score table channels
// Valid/ready interfaces for command beats and result beats.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rst_req_if import rst_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [1:0]                cmd;
	logic signed [SCORE_W-1:0] score;
	logic [NAME_KEY_W-1:0]     name_key;
	logic [COUNT_W-1:0]        count;

	modport source (output valid, cmd, score, name_key, count, input ready);
	modport sink (input valid, cmd, score, name_key, count, output ready);
endinterface

interface rst_rsp_if import rst_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] entry_score;
	logic [NAME_KEY_W-1:0]     entry_name;
	logic [RANK_W-1:0]         rank;
	logic [1:0]                status;
	logic                      last;

	modport source (output valid, entry_score, entry_name, rank, status, last, input ready);
	modport sink (input valid, entry_score, entry_name, rank, status, last, output ready);
endinterface

@@ rtl/rst_cell.sv @@
// ---------------------------------------------------------------------------
// Ranked score table cell
// Holds one entry; compares, shifts and rotates with its neighbours.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rst_cell import rst_pkg::*; #(
	parameter int NW = 8 * RST_NAME_BYTES
) (
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic signed [SCORE_W-1:0] new_score,
	input  logic [NW-1:0]             new_name,
	input  logic                      left_before,
	input  logic signed [SCORE_W-1:0] left_score,
	input  logic [NW-1:0]             left_name,
	input  logic signed [SCORE_W-1:0] right_score,
	input  logic [NW-1:0]             right_name,
	input  logic signed [SCORE_W-1:0] head_score,
	input  logic [NW-1:0]             head_name,
	output logic signed [SCORE_W-1:0] score_q,
	output logic [NW-1:0]             name_q,
	output logic                      before_q
);

	logic new_first;

	// The new entry goes in front of this one on a higher score, or on an
	// equal score with a smaller name. An empty cell always takes it.
	assign new_first = !ctl.occ || (new_score > score_q) ||
		((new_score == score_q) && (new_name < name_q));

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_EVAL: begin
				before_q <= new_first;
			end
			CELL_INSERT: begin
				if (before_q && left_before) begin
					score_q <= left_score;
					name_q  <= left_name;
				end else if (before_q) begin
					score_q <= new_score;
					name_q  <= new_name;
				end
			end
			CELL_ROTATE: begin
				if (ctl.wrap) begin
					score_q <= head_score;
					name_q  <= head_name;
				end else begin
					score_q <= right_score;
					name_q  <= right_name;
				end
			end
			CELL_SHIFT_LEFT: begin
				score_q <= right_score;
				name_q  <= right_name;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/ranked_score_table.sv @@
// ---------------------------------------------------------------------------
// Ranked score table
// Entries sorted by score descending, then name ascending, in a cell row.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Beat carries
//  req      in   cmd, score, name_key, count
//  rsp      out  entry_score, entry_name, rank, status, last
//
// An insert takes the beat, every cell compares the new entry with its own
// in the next cycle, and the row shifts once the result register is free.
// A delete rotates the occupied cells past the head, one a cycle, until
// the name turns up, then drops it and rotates back. A top query streams
// one result a cycle from the head while the row rotates, as long as the
// sink takes them, then finishes the rotation. Reset clears the entry count
// and the control state only. A stalled result holds the sequencer wherever
// a new result would be loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ranked_score_table_macros.svh"

module ranked_score_table import rst_pkg::*; #(
	parameter int DEPTH      = RST_DEPTH,
	parameter int NAME_BYTES = RST_NAME_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	rst_req_if.sink    req,
	rst_rsp_if.source  rsp
);

	localparam int NW = 8 * NAME_BYTES;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int PW = CW + 1;
	localparam int MW = (CW > COUNT_W) ? CW : COUNT_W;

	// Sequencer state and the operands of the beat in progress.
	state_t                    st_q, st_d;
	logic signed [SCORE_W-1:0] score_q;
	logic [NW-1:0]             name_q;
	status_t                   stat_q, stat_d;
	logic [CW-1:0]             cnt_q, cnt_d;
	logic [CW-1:0]             k_q, k_d;
	logic [CW-1:0]             lim_q, lim_d;
	logic                      accept;

	// Result register: it parts the sequencer from the sink.
	logic                      out_valid_q;
	logic signed [SCORE_W-1:0] out_score_q, out_score_d;
	logic [NW-1:0]             out_name_q, out_name_d;
	logic [RANK_W-1:0]         out_rank_q, out_rank_d;
	status_t                   out_stat_q, out_stat_d;
	logic                      out_last_q, out_last_d;
	logic                      out_load;
	logic                      out_free;

	// Cell row.
	cell_op_t                  cell_op;
	cell_ctl_t                 ctl [DEPTH];
	logic signed [SCORE_W-1:0] c_score [DEPTH];
	logic [NW-1:0]             c_name [DEPTH];
	logic [DEPTH-1:0]          c_before;

	// Top query length and insert position.
	logic [MW-1:0]             top_m;
	logic [CW-1:0]             ins_pos;
	logic [CW-1:0]             pos_acc;
	logic [PW-1:0]             pos_probe;

	assign req.ready = (st_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			assign ctl[gi].op   = cell_op;
			assign ctl[gi].occ  = (CW'(gi) < cnt_q);
			assign ctl[gi].wrap = (CW'(gi) == (cnt_q - CW'(1)));

			rst_cell #(.NW(NW)) u_cell (
				.clk         (clk),
				.ctl         (ctl[gi]),
				.new_score   (score_q),
				.new_name    (name_q),
				.left_before ((gi == 0) ? 1'b0 : c_before[(gi == 0) ? 0 : gi - 1]),
				.left_score  ((gi == 0) ? score_q : c_score[(gi == 0) ? 0 : gi - 1]),
				.left_name   ((gi == 0) ? name_q : c_name[(gi == 0) ? 0 : gi - 1]),
				.right_score ((gi == DEPTH - 1) ? c_score[0]
					: c_score[(gi == DEPTH - 1) ? 0 : gi + 1]),
				.right_name  ((gi == DEPTH - 1) ? c_name[0]
					: c_name[(gi == DEPTH - 1) ? 0 : gi + 1]),
				.head_score  (c_score[0]),
				.head_name   (c_name[0]),
				.score_q     (c_score[gi]),
				.name_q      (c_name[gi]),
				.before_q    (c_before[gi])
			);
		end
	endgenerate

	// The compare flags form a thermometer: false up to the insert position,
	// true from there on. A binary search over it counts the false cells.
	always_comb begin
		pos_acc   = '0;
		pos_probe = '0;
		for (int b = CW - 1; b >= 0; b--) begin
			pos_probe = {1'b0, pos_acc} + (PW'(1) << b);
			if ((pos_probe <= PW'(DEPTH)) && !c_before[IW'(pos_probe - PW'(1))]) begin
				pos_acc = pos_probe[CW-1:0];
			end
		end
		ins_pos = pos_acc;
	end

	// A top query is clamped to the entries held and to the result limit.
	always_comb begin
		top_m = MW'(req.count);
		if (top_m > MW'(cnt_q)) begin
			top_m = MW'(cnt_q);
		end
		if (top_m > MW'(MAX_RESULTS)) begin
			top_m = MW'(MAX_RESULTS);
		end
	end

	always_comb begin
		st_d        = st_q;
		stat_d      = stat_q;
		cnt_d       = cnt_q;
		k_d         = k_q;
		lim_d       = lim_q;
		cell_op     = CELL_HOLD;
		out_load    = 1'b0;
		out_score_d = '0;
		out_name_d  = '0;
		out_rank_d  = '0;
		out_stat_d  = STAT_OK;
		out_last_d  = 1'b1;

		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_t'(req.cmd))
						CMD_INSERT: begin
							if (cnt_q == CW'(DEPTH)) begin
								stat_d = STAT_FULL;
								st_d   = ST_STATUS;
							end else begin
								st_d = ST_INS_EVAL;
							end
						end
						CMD_DELETE: begin
							k_d  = '0;
							st_d = ST_DEL_SCAN;
						end
						CMD_TOP: begin
							if (top_m == '0) begin
								stat_d = STAT_EMPTY;
								st_d   = ST_STATUS;
							end else begin
								k_d   = '0;
								lim_d = CW'(top_m);
								st_d  = ST_TOP_EMIT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_INS_EVAL: begin
				cell_op = CELL_EVAL;
				st_d    = ST_INS_APPLY;
			end
			ST_INS_APPLY: begin
				if (out_free) begin
					cell_op     = CELL_INSERT;
					cnt_d       = cnt_q + CW'(1);
					out_load    = 1'b1;
					out_score_d = score_q;
					out_name_d  = name_q;
					out_rank_d  = RANK_W'(ins_pos);
					st_d        = ST_IDLE;
				end
			end
			ST_DEL_SCAN: begin
				if (k_q == cnt_q) begin
					// A full turn without a match: the row is back in order.
					if (out_free) begin
						out_load   = 1'b1;
						out_stat_d = STAT_NOT_FOUND;
						st_d       = ST_IDLE;
					end
				end else if (c_name[0] == name_q) begin
					if (out_free) begin
						out_load    = 1'b1;
						out_score_d = c_score[0];
						out_name_d  = c_name[0];
						out_rank_d  = RANK_W'(k_q);
						cell_op     = CELL_SHIFT_LEFT;
						cnt_d       = cnt_q - CW'(1);
						lim_d       = cnt_q - CW'(1);
						st_d        = (k_q == cnt_q - CW'(1)) ? ST_IDLE : ST_RESTORE;
					end
				end else begin
					cell_op = CELL_ROTATE;
					k_d     = k_q + CW'(1);
				end
			end
			ST_TOP_EMIT: begin
				if (out_free) begin
					out_load    = 1'b1;
					out_score_d = c_score[0];
					out_name_d  = c_name[0];
					out_rank_d  = RANK_W'(k_q);
					out_last_d  = (k_q + CW'(1) == lim_q);
					cell_op     = CELL_ROTATE;
					k_d         = k_q + CW'(1);
					if (k_q + CW'(1) == lim_q) begin
						if (lim_q == cnt_q) begin
							st_d = ST_IDLE;
						end else begin
							lim_d = cnt_q;
							st_d  = ST_RESTORE;
						end
					end
				end
			end
			ST_RESTORE: begin
				cell_op = CELL_ROTATE;
				k_d     = k_q + CW'(1);
				if (k_q + CW'(1) == lim_q) begin
					st_d = ST_IDLE;
				end
			end
			ST_STATUS: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_stat_d = stat_q;
					st_d       = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			stat_q      <= STAT_OK;
			cnt_q       <= '0;
			k_q         <= '0;
			lim_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			stat_q <= stat_d;
			cnt_q  <= cnt_d;
			k_q    <= k_d;
			lim_q  <= lim_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operands and result payload carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			score_q <= req.score;
			name_q  <= req.name_key[NW-1:0];
		end
		if (out_load) begin
			out_score_q <= out_score_d;
			out_name_q  <= out_name_d;
			out_rank_q  <= out_rank_d;
			out_stat_q  <= out_stat_d;
			out_last_q  <= out_last_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.entry_score = out_score_q;
	assign rsp.entry_name  = NAME_KEY_W'(out_name_q);
	assign rsp.rank        = out_rank_q;
	assign rsp.status      = out_stat_q;
	assign rsp.last        = out_last_q;

	// The entry count moves only when an insert lands or a delete drops.
	`RST_ASSERT_SAME(a_cnt_moves, clk, arst_n, cnt_q != $past(cnt_q), $past(st_q) == ST_INS_APPLY || $past(st_q) == ST_DEL_SCAN, "entry count changed outside insert or delete")

	// A result that is not the final one comes only from a top query still going.
	`RST_ASSERT_NEXT(a_more_follows, clk, arst_n, out_load && !out_last_d, st_q == ST_TOP_EMIT, "non-final result outside a top query")

	// An insert taken into a full table goes straight to the status result.
	`RST_ASSERT_NEXT(a_full_insert, clk, arst_n, accept && req.cmd == CMD_INSERT && cnt_q == CW'(DEPTH), st_q == ST_STATUS && stat_q == STAT_FULL, "insert into full table not flagged")

endmodule
